/* rtl/core/splk_pkg.sv */
// ----------------------------------------------------------------------------
// splk_pkg
// Shared types and constants for the sorted pair key lookup unit.
// ----------------------------------------------------------------------------
package splk_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned KindW        = 2;
  localparam int unsigned MaxPairsDef  = 16;

  typedef enum logic [KindW-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;      // empty the list and drop both error flags
    logic append;     // try to append the pair on the input ports
    logic start;      // load the query key and open the search window
    logic probe_rd;   // read the key at the window midpoint
    logic probe_cmp;  // compare and narrow the window
    logic fetch_rd;   // read the lower-bound entry
    logic check;      // load the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic span_zero;  // search window is empty
    logic out_busy;   // output register holds a beat that is not taken
  } status_t;

endpackage

/* rtl/core/splk_ctrl.sv */
// ----------------------------------------------------------------------------
// splk_ctrl
// Controller: accepts input beats and sequences the binary search steps.
// ----------------------------------------------------------------------------
module splk_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [splk_pkg::KindW-1:0]   kind_i,
  input  splk_pkg::status_t            status_i,
  output splk_pkg::cmd_t               cmd_o
);
  import splk_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_PROBE_RD  = 5'b00010,
    ST_PROBE_CMP = 5'b00100,
    ST_FETCH     = 5'b01000,
    ST_CHECK     = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (kind_i)
            KIND_CLEAR:  cmd_o.clear  = 1'b1;
            KIND_APPEND: cmd_o.append = 1'b1;
            KIND_LOOKUP: begin
              cmd_o.start = 1'b1;
              state_d     = ST_PROBE_RD;
            end
            default: ;  // unused kind: drop the beat
          endcase
        end
      end
      ST_PROBE_RD: begin
        if (status_i.span_zero) begin
          state_d = ST_FETCH;
        end else begin
          cmd_o.probe_rd = 1'b1;
          state_d        = ST_PROBE_CMP;
        end
      end
      ST_PROBE_CMP: begin
        cmd_o.probe_cmp = 1'b1;
        state_d         = ST_PROBE_RD;
      end
      ST_FETCH: begin
        cmd_o.fetch_rd = 1'b1;
        state_d        = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status_i.out_busy) begin
          cmd_o.check = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/splk_dp.sv */
// ----------------------------------------------------------------------------
// splk_dp
// Datapath: pair stores, list count, error flags, search window and result.
// ----------------------------------------------------------------------------
module splk_dp #(
  parameter int unsigned MaxPairs = splk_pkg::MaxPairsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  splk_pkg::cmd_t                     cmd_i,
  output splk_pkg::status_t                  status_o,
  input  logic signed [splk_pkg::DataW-1:0]  pair_key_i,
  input  logic signed [splk_pkg::DataW-1:0]  pair_value_i,
  input  logic signed [splk_pkg::DataW-1:0]  query_key_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               found_o,
  output logic signed [splk_pkg::DataW-1:0]  found_value_o,
  output logic                               order_error_o,
  output logic                               overflow_error_o
);
  import splk_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxPairs + 1);
  localparam int unsigned AddrW = $clog2(MaxPairs);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxPairs);

  // Pair stores, one write and one registered read per cycle
  logic signed [DataW-1:0] key_mem [MaxPairs];
  logic signed [DataW-1:0] val_mem [MaxPairs];

  logic [CntW-1:0]         count_q, count_d;
  logic                    order_q, order_d;
  logic                    ovf_q, ovf_d;
  logic [CntW-1:0]         lo_q, lo_d;
  logic [CntW-1:0]         span_q, span_d;
  logic                    out_valid_q, out_valid_d;
  logic                    fetch_ok_q;
  logic signed [DataW-1:0] last_key_q;
  logic signed [DataW-1:0] qk_q;
  logic signed [DataW-1:0] key_rd_q;
  logic signed [DataW-1:0] val_rd_q;
  logic                    found_q;
  logic signed [DataW-1:0] found_value_q;
  logic                    order_out_q;
  logic                    ovf_out_q;

  logic [CntW-1:0]  half;
  logic [CntW-1:0]  mid;
  logic             full;
  logic             out_of_order;
  logic             wr_en;
  logic             lo_in_list;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             hit;

  assign half         = span_q >> 1;
  assign mid          = lo_q + half;
  assign full         = (count_q >= CntMax);
  assign out_of_order = (count_q != '0) && (pair_key_i <= last_key_q);
  assign wr_en        = cmd_i.append && !full && !out_of_order;
  assign lo_in_list   = (lo_q < count_q);
  assign rd_en        = cmd_i.probe_rd || (cmd_i.fetch_rd && lo_in_list);
  assign rd_addr      = cmd_i.fetch_rd ? lo_q[AddrW-1:0] : mid[AddrW-1:0];
  assign hit          = fetch_ok_q && (key_rd_q == qk_q);

  always_comb begin
    count_d     = count_q;
    order_d     = order_q;
    ovf_d       = ovf_q;
    lo_d        = lo_q;
    span_d      = span_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.clear) begin
      count_d = '0;
      order_d = 1'b0;
      ovf_d   = 1'b0;
    end
    if (cmd_i.append) begin
      if (full) begin
        ovf_d = 1'b1;
      end else if (out_of_order) begin
        order_d = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
    if (cmd_i.start) begin
      lo_d   = '0;
      span_d = count_q;
    end
    if (cmd_i.probe_cmp) begin
      if (key_rd_q < qk_q) begin
        lo_d   = mid + 1'b1;
        span_d = span_q - half - 1'b1;
      end else begin
        span_d = half;
      end
    end
    if (cmd_i.check) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      order_q     <= 1'b0;
      ovf_q       <= 1'b0;
      lo_q        <= '0;
      span_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      order_q     <= order_d;
      ovf_q       <= ovf_d;
      lo_q        <= lo_d;
      span_q      <= span_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      last_key_q <= pair_key_i;
    end
    if (cmd_i.start) begin
      qk_q <= query_key_i;
    end
    if (cmd_i.fetch_rd) begin
      fetch_ok_q <= lo_in_list;
    end
    if (cmd_i.check) begin
      found_q       <= hit;
      found_value_q <= hit ? val_rd_q : '0;
      order_out_q   <= order_q;
      ovf_out_q     <= ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[count_q[AddrW-1:0]] <= pair_key_i;
      val_mem[count_q[AddrW-1:0]] <= pair_value_i;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[rd_addr];
      val_rd_q <= val_mem[rd_addr];
    end
  end

  assign status_o.span_zero = (span_q == '0);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign found_o          = found_q;
  assign found_value_o    = found_value_q;
  assign order_error_o    = order_out_q;
  assign overflow_error_o = ovf_out_q;

endmodule

/* rtl/core/sorted_pair_key_lookup_unit.sv */
// ----------------------------------------------------------------------------
// sorted_pair_key_lookup_unit
// Sorted (key, value) list with lower-bound binary search lookup.
// ----------------------------------------------------------------------------
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------
//   in      | in_valid_i/in_ready_o   | kind_i, pair_key_i, pair_value_i,
//           |                         | query_key_i
//   out     | out_valid_o/out_ready_i | found_o, found_value_o,
//           |                         | order_error_o, overflow_error_o
//
// A lookup loads the query key, runs at most floor(log2(entries)) + 1 probes,
// reads the lower-bound entry and loads the result; each probe reads the key
// store through its one registered port, then compares. Reset empties the list
// and drops both flags; the stores are not cleared. A result beat waits in the
// output register while clear and append beats keep flowing; a second lookup
// holds in its last step until the beat is taken.
// ----------------------------------------------------------------------------
module sorted_pair_key_lookup_unit #(
  parameter int unsigned MaxPairs = splk_pkg::MaxPairsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [splk_pkg::KindW-1:0]         kind_i,
  input  logic signed [splk_pkg::DataW-1:0]  pair_key_i,
  input  logic signed [splk_pkg::DataW-1:0]  pair_value_i,
  input  logic signed [splk_pkg::DataW-1:0]  query_key_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               found_o,
  output logic signed [splk_pkg::DataW-1:0]  found_value_o,
  output logic                               order_error_o,
  output logic                               overflow_error_o
);
  import splk_pkg::*;

  cmd_t    ctrl_cmd;
  status_t dp_status;

  // Sequence the search steps
  splk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  // Hold the list, the flags, the search window and the result beat
  splk_dp #(
    .MaxPairs (MaxPairs)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .status_o         (dp_status),
    .pair_key_i       (pair_key_i),
    .pair_value_i     (pair_value_i),
    .query_key_i      (query_key_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_o          (found_o),
    .found_value_o    (found_value_o),
    .order_error_o    (order_error_o),
    .overflow_error_o (overflow_error_o)
  );

  // At most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ctrl_cmd))
    else $error("controller issued more than one command");

  // Never overwrite a result beat that is still waiting
  a_check_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.check |-> !dp_status.out_busy)
    else $error("result loaded over a pending beat");

  // A loaded result shows up as a valid beat
  a_check_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.check |=> out_valid_o)
    else $error("result loaded but no beat offered");

  // A lookup blocks the input until its search ends
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.start |=> !in_ready_o)
    else $error("input taken during a search");

endmodule
